/* design/hsnc_pkg.sv */
// Shared types, constants and the stencil table of the half-shell neighbor cell stencil core.
// Depends on nothing; every other file of the block imports it.
package hsnc_pkg;

    // Field widths
    localparam int STENCIL_SIZE = 13;
    localparam int SLOT_W       = 4;
    localparam int COORD_W      = 6;
    localparam int CNT_W        = 7;
    localparam int AREA_W       = 2 * CNT_W;
    localparam int VOL_W        = CNT_W + AREA_W;
    localparam int INDEX_W      = 18;
    localparam int SHIFT_W      = 2;
    localparam int ADDR_W       = 3;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 32;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] REG_CELLS_X    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_CELLS_Y    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_CELLS_Z    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_PERIODIC_X = 3'd3;
    localparam logic [ADDR_W-1:0] REG_PERIODIC_Y = 3'd4;
    localparam logic [ADDR_W-1:0] REG_PERIODIC_Z = 3'd5;

    // Offset and shift codes, two's complement
    localparam logic [SHIFT_W-1:0] OFF_ZERO = 2'b00;
    localparam logic [SHIFT_W-1:0] OFF_POS  = 2'b01;
    localparam logic [SHIFT_W-1:0] OFF_NEG  = 2'b11;

    typedef struct packed {
        logic [CNT_W-1:0] cells_x;
        logic [CNT_W-1:0] cells_y;
        logic [CNT_W-1:0] cells_z;
        logic             periodic_x;
        logic             periodic_y;
        logic             periodic_z;
    } cfg_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] oz;
        logic [SHIFT_W-1:0] oy;
        logic [SHIFT_W-1:0] ox;
    } offs_t;

    // One stencil slot of one home cell, as issued by the sequencer.
    typedef struct packed {
        logic [COORD_W-1:0] home_x;
        logic [COORD_W-1:0] home_y;
        logic [COORD_W-1:0] home_z;
        logic [SLOT_W-1:0]  slot;
        logic               empty;
        logic               last;
    } token_t;

    // A resolved neighbor coordinate with its image shifts.
    typedef struct packed {
        logic [CNT_W-1:0]   x;
        logic [CNT_W-1:0]   y;
        logic [CNT_W-1:0]   z;
        logic [SHIFT_W-1:0] shift_x;
        logic [SHIFT_W-1:0] shift_y;
        logic [SHIFT_W-1:0] shift_z;
        logic [SLOT_W-1:0]  slot;
        logic               empty;
        logic               last;
    } coord_t;

    // Half-shell offsets in table order.
    function automatic offs_t stencil_offsets(input logic [SLOT_W-1:0] slot);
        offs_t o;
        o = '{oz: OFF_ZERO, oy: OFF_ZERO, ox: OFF_ZERO};
        unique case (slot)
            4'd0:    o = '{oz: OFF_ZERO, oy: OFF_ZERO, ox: OFF_POS};
            4'd1:    o = '{oz: OFF_ZERO, oy: OFF_POS,  ox: OFF_POS};
            4'd2:    o = '{oz: OFF_ZERO, oy: OFF_POS,  ox: OFF_ZERO};
            4'd3:    o = '{oz: OFF_ZERO, oy: OFF_POS,  ox: OFF_NEG};
            4'd4:    o = '{oz: OFF_POS,  oy: OFF_ZERO, ox: OFF_ZERO};
            4'd5:    o = '{oz: OFF_POS,  oy: OFF_ZERO, ox: OFF_POS};
            4'd6:    o = '{oz: OFF_POS,  oy: OFF_POS,  ox: OFF_POS};
            4'd7:    o = '{oz: OFF_POS,  oy: OFF_POS,  ox: OFF_ZERO};
            4'd8:    o = '{oz: OFF_POS,  oy: OFF_POS,  ox: OFF_NEG};
            4'd9:    o = '{oz: OFF_POS,  oy: OFF_ZERO, ox: OFF_NEG};
            4'd10:   o = '{oz: OFF_POS,  oy: OFF_NEG,  ox: OFF_NEG};
            4'd11:   o = '{oz: OFF_POS,  oy: OFF_NEG,  ox: OFF_ZERO};
            4'd12:   o = '{oz: OFF_POS,  oy: OFF_NEG,  ox: OFF_POS};
            default: o = '{oz: OFF_ZERO, oy: OFF_ZERO, ox: OFF_ZERO};
        endcase
        return o;
    endfunction

endpackage

/* design/hsnc_issue.sv */
// Input stage and slot sequencer: holds one home cell with its mask of valid stencil slots
// and issues one token per cycle while advance is high. Depends on hsnc_pkg.
module hsnc_issue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hsnc_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hsnc_pkg::COORD_W-1:0] in_x,
    input  logic [hsnc_pkg::COORD_W-1:0] in_y,
    input  logic [hsnc_pkg::COORD_W-1:0] in_z,
    input  logic                         advance,
    output logic                         tok_valid,
    output hsnc_pkg::token_t             tok
);
    import hsnc_pkg::*;

    logic                    item_vld_reg, item_vld_next;
    logic [COORD_W-1:0]      home_x_reg, home_y_reg, home_z_reg;
    logic [STENCIL_SIZE-1:0] mask_reg, mask_next;
    logic [STENCIL_SIZE-1:0] new_mask, rest_mask;
    logic [SLOT_W-1:0]       slot_sel;
    logic                    in_grid, fire, done, take;
    logic                    pos_x, pos_y, pos_z, neg_x, neg_y, neg_z;
    offs_t                   offs;

    function automatic logic offset_ok(input logic [SHIFT_W-1:0] off, input logic neg_ok,
                                       input logic pos_ok);
        logic ok;
        ok = 1'b1;
        if (off == OFF_POS)
            ok = pos_ok;
        else if (off == OFF_NEG)
            ok = neg_ok;
        return ok;
    endfunction

    // Per-axis validity of each offset direction for the incoming home cell.
    always_comb
    begin
        in_grid = ({1'b0, in_x} < cfg.cells_x) && ({1'b0, in_y} < cfg.cells_y)
               && ({1'b0, in_z} < cfg.cells_z);
        pos_x = (({1'b0, in_x} + 7'd1) < cfg.cells_x) || cfg.periodic_x;
        pos_y = (({1'b0, in_y} + 7'd1) < cfg.cells_y) || cfg.periodic_y;
        pos_z = (({1'b0, in_z} + 7'd1) < cfg.cells_z) || cfg.periodic_z;
        neg_x = (in_x != '0) || cfg.periodic_x;
        neg_y = (in_y != '0) || cfg.periodic_y;
        neg_z = (in_z != '0) || cfg.periodic_z;
        offs  = '0;
        for (int i = 0; i < STENCIL_SIZE; i++)
        begin
            offs = stencil_offsets(SLOT_W'(i));
            new_mask[i] = in_grid && offset_ok(offs.ox, neg_x, pos_x)
                       && offset_ok(offs.oy, neg_y, pos_y)
                       && offset_ok(offs.oz, neg_z, pos_z);
        end
    end

    // Lowest pending slot goes out first.
    always_comb
    begin
        slot_sel = '0;
        for (int i = STENCIL_SIZE - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                slot_sel = SLOT_W'(i);
        end
        rest_mask = mask_reg & (mask_reg - STENCIL_SIZE'(1));
    end

    // Token and handshake.
    always_comb
    begin
        tok.home_x = home_x_reg;
        tok.home_y = home_y_reg;
        tok.home_z = home_z_reg;
        tok.slot   = slot_sel;
        tok.empty  = (mask_reg == '0);
        tok.last   = (rest_mask == '0);
        tok_valid  = item_vld_reg;
        fire       = item_vld_reg && advance;
        done       = fire && tok.last;
        in_ready   = !item_vld_reg || done;
        take       = in_valid && in_ready;
    end

    // Next item state.
    always_comb
    begin
        item_vld_next = item_vld_reg;
        mask_next     = mask_reg;
        if (take)
        begin
            item_vld_next = 1'b1;
            mask_next     = new_mask;
        end
        else if (done)
        begin
            item_vld_next = 1'b0;
        end
        else if (fire)
        begin
            mask_next = rest_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else
            item_vld_reg <= item_vld_next;
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        if (take)
        begin
            home_x_reg <= in_x;
            home_y_reg <= in_y;
            home_z_reg <= in_z;
        end
    end

endmodule

/* design/hsnc_fold.sv */
// Axis fold stage: applies the stencil offset to each axis and wraps across periodic
// boundaries, recording the image shift. Depends on hsnc_pkg.
module hsnc_fold (
    input  logic             clk,
    input  logic             rst_n,
    input  hsnc_pkg::cfg_t   cfg,
    input  logic             advance,
    input  logic             tok_valid,
    input  hsnc_pkg::token_t tok,
    output logic             crd_valid,
    output hsnc_pkg::coord_t crd
);
    import hsnc_pkg::*;

    logic   vld_reg;
    coord_t crd_reg, crd_next;
    offs_t  offs;
    logic [CNT_W+SHIFT_W-1:0] fx, fy, fz;

    // One axis; the slot mask guarantees that the home cell is in range and the move legal.
    function automatic logic [CNT_W+SHIFT_W-1:0] axis_fold(input logic [COORD_W-1:0] home,
                                                          input logic [SHIFT_W-1:0] off,
                                                          input logic [CNT_W-1:0]   n);
        logic [CNT_W-1:0]   up;
        logic [CNT_W-1:0]   coord;
        logic [SHIFT_W-1:0] shift;
        up    = {1'b0, home} + CNT_W'(1);
        coord = {1'b0, home};
        shift = OFF_ZERO;
        if (off == OFF_POS)
        begin
            if (up >= n)
            begin
                coord = '0;
                shift = OFF_POS;
            end
            else
            begin
                coord = up;
            end
        end
        else if (off == OFF_NEG)
        begin
            if (home == '0)
            begin
                coord = n - CNT_W'(1);
                shift = OFF_NEG;
            end
            else
            begin
                coord = {1'b0, home} - CNT_W'(1);
            end
        end
        return {shift, coord};
    endfunction

    always_comb
    begin
        offs = stencil_offsets(tok.slot);
        fx   = axis_fold(tok.home_x, offs.ox, cfg.cells_x);
        fy   = axis_fold(tok.home_y, offs.oy, cfg.cells_y);
        fz   = axis_fold(tok.home_z, offs.oz, cfg.cells_z);
        // The empty result carries zeros in every field but the empty and last flags.
        if (tok.empty)
        begin
            crd_next = '0;
        end
        else
        begin
            crd_next.x       = fx[CNT_W-1:0];
            crd_next.y       = fy[CNT_W-1:0];
            crd_next.z       = fz[CNT_W-1:0];
            crd_next.shift_x = fx[CNT_W+SHIFT_W-1:CNT_W];
            crd_next.shift_y = fy[CNT_W+SHIFT_W-1:CNT_W];
            crd_next.shift_z = fz[CNT_W+SHIFT_W-1:CNT_W];
            crd_next.slot    = tok.slot;
            crd_next.empty   = 1'b0;
        end
        crd_next.empty = tok.empty;
        crd_next.last  = tok.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (advance)
            vld_reg <= tok_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            crd_reg <= crd_next;
    end

    assign crd_valid = vld_reg;
    assign crd       = crd_reg;

endmodule

/* design/hsnc_index.sv */
// Linear index stages: one register stage of products, then the sum into the output
// register that drives the result stream. Depends on hsnc_pkg.
module hsnc_index (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hsnc_pkg::cfg_t                  cfg,
    input  logic [hsnc_pkg::AREA_W-1:0]     area,
    input  logic                            advance,
    input  logic                            crd_valid,
    input  hsnc_pkg::coord_t                crd,
    output logic                            out_valid,
    output logic [hsnc_pkg::INDEX_W-1:0]    out_index,
    output logic [hsnc_pkg::SHIFT_W-1:0]    out_shift_x,
    output logic [hsnc_pkg::SHIFT_W-1:0]    out_shift_y,
    output logic [hsnc_pkg::SHIFT_W-1:0]    out_shift_z,
    output logic [hsnc_pkg::SLOT_W-1:0]     out_slot,
    output logic                            out_empty,
    output logic                            out_last
);
    import hsnc_pkg::*;

    logic               prod_vld_reg, out_vld_reg;
    coord_t             prod_crd_reg;
    logic [AREA_W-1:0]  py_reg;
    logic [VOL_W-1:0]   pz_reg;
    logic [INDEX_W-1:0] index_reg, index_next;
    coord_t             out_crd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prod_vld_reg <= crd_valid;
            out_vld_reg  <= prod_vld_reg;
        end
    end

    // Products of the row and plane strides.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_crd_reg <= crd;
            py_reg       <= AREA_W'(crd.y) * AREA_W'(cfg.cells_x);
            pz_reg       <= VOL_W'(crd.z) * VOL_W'(area);
        end
    end

    // Sum wraps to the index width.
    assign index_next = INDEX_W'(pz_reg) + INDEX_W'(py_reg) + INDEX_W'(prod_crd_reg.x);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg   <= index_next;
            out_crd_reg <= prod_crd_reg;
        end
    end

    assign out_valid   = out_vld_reg;
    assign out_index   = index_reg;
    assign out_shift_x = out_crd_reg.shift_x;
    assign out_shift_y = out_crd_reg.shift_y;
    assign out_shift_z = out_crd_reg.shift_z;
    assign out_slot    = out_crd_reg.slot;
    assign out_empty   = out_crd_reg.empty;
    assign out_last    = out_crd_reg.last;

endmodule

/* design/half_shell_neighbor_cell_stencil_core.sv */
// Top level of the half-shell neighbor cell stencil core: configuration registers and the
// sequencer, fold and index stages. Depends on hsnc_pkg, hsnc_issue, hsnc_fold, hsnc_index.
//
//  Channel  Direction  Payload
//  s_*      in         tdata: cell_x[5:0], cell_y[11:6], cell_z[17:12], zero fill to 24 bits
//  m_*      out        tdata: neighbor_index, shifts, stencil_slot; tuser: empty_res; tlast
//  cfg_*    in         cfg_addr selects the register, cfg_wdata is written on cfg_we
//
// Each home cell holds the sequencer for one issue per valid neighbor slot, or one if it
// has none. Results leave at one per cycle unless m_tready stalls them, passing through
// the fold, product and output registers. The next item is taken as the last slot issues.
// Reset clears the valid bits and sets the grid to 1x1x1 with no periodic axes.
// A stall on m_tready freezes all stages together; nothing is dropped or repeated.
module half_shell_neighbor_cell_stencil_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hsnc_pkg::IN_DATA_W-1:0]    s_tdata,    // cell_x, cell_y, cell_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // neighbor_index, shift_x, shift_y, shift_z, stencil_slot
    output logic [hsnc_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,    // empty_res
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [hsnc_pkg::ADDR_W-1:0]       cfg_addr,
    input  logic [hsnc_pkg::CNT_W-1:0]        cfg_wdata
);
    import hsnc_pkg::*;

    cfg_t               cfg_reg;
    logic [AREA_W-1:0]  area_reg;
    logic               advance;
    logic               tok_valid, crd_valid;
    token_t             tok;
    coord_t             crd;
    logic [INDEX_W-1:0] out_index;
    logic [SHIFT_W-1:0] out_shift_x, out_shift_y, out_shift_z;
    logic [SLOT_W-1:0]  out_slot;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cells_x    <= CNT_W'(1);
            cfg_reg.cells_y    <= CNT_W'(1);
            cfg_reg.cells_z    <= CNT_W'(1);
            cfg_reg.periodic_x <= 1'b0;
            cfg_reg.periodic_y <= 1'b0;
            cfg_reg.periodic_z <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CELLS_X:    cfg_reg.cells_x    <= cfg_wdata;
                REG_CELLS_Y:    cfg_reg.cells_y    <= cfg_wdata;
                REG_CELLS_Z:    cfg_reg.cells_z    <= cfg_wdata;
                REG_PERIODIC_X: cfg_reg.periodic_x <= cfg_wdata[0];
                REG_PERIODIC_Y: cfg_reg.periodic_y <= cfg_wdata[0];
                REG_PERIODIC_Z: cfg_reg.periodic_z <= cfg_wdata[0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Plane size, refreshed every cycle from the registered counts.
    always_ff @(posedge clk)
    begin
        area_reg <= AREA_W'(cfg_reg.cells_x) * AREA_W'(cfg_reg.cells_y);
    end

    // The whole pipeline moves when the output register is free or being drained.
    assign advance = !m_tvalid || m_tready;

    hsnc_issue u_issue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[COORD_W-1:0]),
        .in_y      (s_tdata[2*COORD_W-1:COORD_W]),
        .in_z      (s_tdata[3*COORD_W-1:2*COORD_W]),
        .advance   (advance),
        .tok_valid (tok_valid),
        .tok       (tok)
    );

    hsnc_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .advance   (advance),
        .tok_valid (tok_valid),
        .tok       (tok),
        .crd_valid (crd_valid),
        .crd       (crd)
    );

    hsnc_index u_index (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .area        (area_reg),
        .advance     (advance),
        .crd_valid   (crd_valid),
        .crd         (crd),
        .out_valid   (m_tvalid),
        .out_index   (out_index),
        .out_shift_x (out_shift_x),
        .out_shift_y (out_shift_y),
        .out_shift_z (out_shift_z),
        .out_slot    (out_slot),
        .out_empty   (m_tuser),
        .out_last    (m_tlast)
    );

    // Result packing, lowest field first.
    assign m_tdata = {4'b0000, out_slot, out_shift_z, out_shift_y, out_shift_x, out_index};

endmodule
